@@ src/row_chain_merge_core_defines.svh @@
// Assertion macros for the row chain merge core.
// Used by the top level only; needs nothing else.
`ifndef ROW_CHAIN_MERGE_CORE_DEFINES_SVH
`define ROW_CHAIN_MERGE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define RCM_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("row_chain_merge_core: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define RCM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("row_chain_merge_core: next-cycle check failed");

`endif

@@ src/rcm_pkg.sv @@
// Shared types and constants for the row chain merge core.
// No dependencies; used by rcm_ctrl, rcm_datapath and row_chain_merge_core.
`default_nettype none

package rcm_pkg;

  localparam int ROWS      = 256;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int FIELD_W   = 8;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 24;

  // Row limit at one bit above the field width, so that sums compare cleanly.
  localparam logic [FIELD_W:0] ROWS_LIM = (FIELD_W + 1)'(ROWS);

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_JOIN  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_READ_TAKE,
    S_FOLLOW,
    S_DECIDE,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_IN,
    OP_WRITE,
    OP_READ,
    OP_READ_TAKE,
    OP_JOIN_START,
    OP_FOLLOW,
    OP_LINK,
    OP_LOAD_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       join_walk;
    logic       walk_stop;
    logic       out_free;
    logic       link_rising;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ src/row_chain_merge_core.sv @@
// Top level of the row chain merge core: controller plus datapath.
// Depends on rcm_pkg, rcm_ctrl, rcm_datapath and the assertion macro header.
//
// The core keeps a step store of 256 rows and handles one command at a time.
// After acceptance a write, or a join that needs no walk, passes the dispatch
// and done states, and a read passes dispatch, read-take and done; a join
// that walks the chains passes follow and decide for each node followed, a
// read-then-update loop over the single read port of the step store. The
// next transaction is accepted in the cycle after the result is loaded, even
// if that result is not yet taken; a result still waiting in the output
// register holds the next one back in the core.
// The store reads as all zero after reset without any clearing pass.
`default_nettype none
`include "row_chain_merge_core_defines.svh"

module row_chain_merge_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // s_tdata from bit 0: row[7:0], step_in[15:8], chain_a[23:16], a_present[24],
  // chain_b[32:25], b_present[33], zero fill up to bit 39.
  input  wire logic [rcm_pkg::S_TDATA_W-1:0] s_tdata,
  // s_tuser from bit 0: command[1:0].
  input  wire logic [1:0]                    s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // m_tdata from bit 0: head[7:0], head_present[8], step_out[16:9], error[17],
  // zero fill up to bit 23.
  output logic [rcm_pkg::M_TDATA_W-1:0]      m_tdata
);

  rcm_pkg::dp_ctl_t  ctl;
  rcm_pkg::dp_stat_t stat;

  rcm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .ctl      (ctl),
    .stat     (stat)
  );

  rcm_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .ctl      (ctl),
    .stat     (stat)
  );

  // Only one command is in work at a time.
  `RCM_ASSERT_NEXT(a_one_in_work, clk, rst, s_tvalid && s_tready, !s_tready)
  // Loading a result always shows it on the output.
  `RCM_ASSERT_NEXT(a_result_shown, clk, rst, ctl.op == rcm_pkg::OP_LOAD_OUT, m_tvalid)
  // The merged chain only ever links forward.
  `RCM_ASSERT_IMPL(a_link_rises, clk, rst, ctl.op == rcm_pkg::OP_LINK, stat.link_rising)

endmodule

`default_nettype wire

@@ src/rcm_ctrl.sv @@
// Controller state machine of the row chain merge core.
// Depends on rcm_pkg; drives the datapath through rcm_pkg::dp_ctl_t.
`default_nettype none

module rcm_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  output rcm_pkg::dp_ctl_t      ctl,
  input  wire rcm_pkg::dp_stat_t stat
);

  rcm_pkg::state_t state;
  rcm_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rcm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rcm_pkg::S_IDLE: begin
        if (s_tvalid) state_next = rcm_pkg::S_DISPATCH;
      end
      rcm_pkg::S_DISPATCH: begin
        case (stat.cmd)
          rcm_pkg::CMD_READ: state_next = rcm_pkg::S_READ_TAKE;
          rcm_pkg::CMD_JOIN: begin
            state_next = stat.join_walk ? rcm_pkg::S_FOLLOW : rcm_pkg::S_DONE;
          end
          default: state_next = rcm_pkg::S_DONE;
        endcase
      end
      rcm_pkg::S_READ_TAKE: state_next = rcm_pkg::S_DONE;
      rcm_pkg::S_FOLLOW:    state_next = rcm_pkg::S_DECIDE;
      rcm_pkg::S_DECIDE: begin
        state_next = stat.walk_stop ? rcm_pkg::S_DONE : rcm_pkg::S_FOLLOW;
      end
      rcm_pkg::S_DONE: begin
        if (stat.out_free) state_next = rcm_pkg::S_IDLE;
      end
      default: state_next = rcm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    ctl.op   = rcm_pkg::OP_NONE;
    unique case (state)
      rcm_pkg::S_IDLE: begin
        // Nothing is taken while reset is held.
        s_tready = !rst;
        if (s_tvalid && !rst) ctl.op = rcm_pkg::OP_LOAD_IN;
      end
      rcm_pkg::S_DISPATCH: begin
        case (stat.cmd)
          rcm_pkg::CMD_WRITE: ctl.op = rcm_pkg::OP_WRITE;
          rcm_pkg::CMD_READ:  ctl.op = rcm_pkg::OP_READ;
          rcm_pkg::CMD_JOIN:  ctl.op = rcm_pkg::OP_JOIN_START;
          default:            ctl.op = rcm_pkg::OP_NONE;
        endcase
      end
      rcm_pkg::S_READ_TAKE: ctl.op = rcm_pkg::OP_READ_TAKE;
      rcm_pkg::S_FOLLOW:    ctl.op = rcm_pkg::OP_FOLLOW;
      rcm_pkg::S_DECIDE: begin
        if (!stat.walk_stop) ctl.op = rcm_pkg::OP_LINK;
      end
      rcm_pkg::S_DONE: begin
        if (stat.out_free) ctl.op = rcm_pkg::OP_LOAD_OUT;
      end
      default: ctl.op = rcm_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

@@ src/rcm_datapath.sv @@
// Datapath of the row chain merge core: step store, chain walk registers
// and the output register. Depends on rcm_pkg; commanded by rcm_ctrl.
`default_nettype none

module rcm_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [rcm_pkg::S_TDATA_W-1:0] s_tdata,
  input  wire logic [1:0]                    s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [rcm_pkg::M_TDATA_W-1:0]      m_tdata,
  input  wire rcm_pkg::dp_ctl_t              ctl,
  output rcm_pkg::dp_stat_t                  stat
);

  localparam int FW = rcm_pkg::FIELD_W;
  localparam int RW = rcm_pkg::ROW_W;

  // Step store; an entry not yet written reads as zero through its valid bit.
  logic [FW-1:0]           mem [rcm_pkg::ROWS];
  logic [rcm_pkg::ROWS-1:0] vld;
  logic [FW-1:0]           rd_q;
  logic                    rd_vld_q;

  logic          wr_en;
  logic [RW-1:0] wr_addr;
  logic [FW-1:0] wr_data;
  logic          rd_en;
  logic [RW-1:0] rd_addr;

  // Latched command and walk registers.
  logic [1:0]    cmd;
  logic [FW-1:0] row;
  logic [FW-1:0] step_in;
  logic [FW-1:0] a;
  logic          ap;
  logic [FW-1:0] b;
  logic          bp;
  logic [FW-1:0] q;
  logic          sel_a;
  logic [FW-1:0] head;
  logic          head_present;
  logic [FW-1:0] step_out;
  logic          err;

  logic          row_ok;
  logic          a_oor;
  logic          b_oor;
  logic          a_lt_b;
  logic [FW-1:0] min_ab;
  logic          take_a;
  logic [FW-1:0] link_row;
  logic [FW-1:0] pos;
  logic [FW-1:0] rd_step;
  logic [FW:0]   pos_sum;
  logic          overrun;

  always_comb begin
    row_ok   = {1'b0, row} < rcm_pkg::ROWS_LIM;
    a_oor    = ap && ({1'b0, a} >= rcm_pkg::ROWS_LIM);
    b_oor    = bp && ({1'b0, b} >= rcm_pkg::ROWS_LIM);
    a_lt_b   = a < b;
    min_ab   = a_lt_b ? a : b;
    take_a   = ap && (!bp || a_lt_b);
    link_row = take_a ? a : b;
    pos      = sel_a ? a : b;
    rd_step  = rd_vld_q ? rd_q : '0;
    pos_sum  = {1'b0, pos} + {1'b0, rd_step};
    overrun  = pos_sum >= rcm_pkg::ROWS_LIM;
  end

  always_comb begin
    stat.cmd         = cmd;
    stat.join_walk   = !a_oor && !b_oor && ap && bp && (a != b);
    stat.walk_stop   = err || (!ap && !bp) || (ap && bp && (a == b));
    stat.out_free    = !m_tvalid || m_tready;
    stat.link_rising = link_row > q;
  end

  // Store port selection.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = row[RW-1:0];
    wr_data = step_in;
    rd_en   = 1'b0;
    rd_addr = row[RW-1:0];
    case (ctl.op)
      rcm_pkg::OP_WRITE: wr_en = row_ok;
      rcm_pkg::OP_READ:  rd_en = row_ok;
      rcm_pkg::OP_JOIN_START: begin
        rd_en   = stat.join_walk;
        rd_addr = min_ab[RW-1:0];
      end
      rcm_pkg::OP_LINK: begin
        wr_en   = 1'b1;
        wr_addr = q[RW-1:0];
        wr_data = link_row - q;
        rd_en   = 1'b1;
        rd_addr = link_row[RW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      rd_vld_q <= vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (wr_en) vld[wr_addr] <= 1'b1;
      if (ctl.op == rcm_pkg::OP_LOAD_OUT) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      rcm_pkg::OP_LOAD_IN: begin
        cmd          <= s_tuser;
        row          <= s_tdata[7:0];
        step_in      <= s_tdata[15:8];
        a            <= s_tdata[23:16];
        ap           <= s_tdata[24];
        b            <= s_tdata[32:25];
        bp           <= s_tdata[33];
        head         <= '0;
        head_present <= 1'b0;
        step_out     <= '0;
        err          <= 1'b0;
      end
      rcm_pkg::OP_WRITE: err <= !row_ok;
      rcm_pkg::OP_READ:  err <= !row_ok;
      rcm_pkg::OP_READ_TAKE: begin
        if (row_ok) step_out <= rd_step;
      end
      rcm_pkg::OP_JOIN_START: begin
        if (a_oor || b_oor) begin
          err <= 1'b1;
        end else if (!ap || !bp) begin
          if (ap) begin
            head         <= a;
            head_present <= 1'b1;
          end else if (bp) begin
            head         <= b;
            head_present <= 1'b1;
          end
        end else begin
          // Equal heads fall in here too: the minimum is then that head.
          head         <= min_ab;
          head_present <= 1'b1;
          q            <= min_ab;
          sel_a        <= a_lt_b;
        end
      end
      rcm_pkg::OP_FOLLOW: begin
        if (rd_step == '0) begin
          if (sel_a) ap <= 1'b0;
          else bp <= 1'b0;
        end else if (overrun) begin
          err <= 1'b1;
        end else if (sel_a) begin
          a <= pos_sum[FW-1:0];
        end else begin
          b <= pos_sum[FW-1:0];
        end
      end
      rcm_pkg::OP_LINK: begin
        q     <= link_row;
        sel_a <= take_a;
      end
      rcm_pkg::OP_LOAD_OUT: begin
        m_tdata <= {6'd0, err, step_out, head_present, head};
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
